/* hdl/smb_pkg.sv */
package smb_pkg;

  // Access kinds carried in the input tuser.
  localparam logic [1:0] KIND_CPU_RD = 2'd0;
  localparam logic [1:0] KIND_CPU_WR = 2'd1;
  localparam logic [1:0] KIND_PPU_RD = 2'd2;
  localparam logic [1:0] KIND_PPU_WR = 2'd3;

  // Target memory codes carried in the output tuser.
  localparam logic [1:0] TGT_NONE    = 2'd0;
  localparam logic [1:0] TGT_PRG_ROM = 2'd1;
  localparam logic [1:0] TGT_PRG_RAM = 2'd2;
  localparam logic [1:0] TGT_CHR     = 2'd3;

  // Configuration register indexes (byte address / 4).
  localparam logic [1:0] REG_PRG_ROM_BANKS    = 2'd0;
  localparam logic [1:0] REG_CHR_ADDRESS_MASK = 2'd1;
  localparam logic [1:0] REG_PRG_RAM_PRESENT  = 2'd2;

  // Serial register select, address bits 14:13.
  localparam logic [1:0] SEL_CONTROL  = 2'd0;
  localparam logic [1:0] SEL_CHR_LOW  = 2'd1;
  localparam logic [1:0] SEL_CHR_HIGH = 2'd2;
  localparam logic [1:0] SEL_PRG      = 2'd3;

  localparam int PrgRamBytes = 8192;
  localparam int PrgRamAw    = $clog2(PrgRamBytes);

  localparam int CfgAw   = 4;
  localparam int MapAw   = 18;
  localparam int ChrAw   = 17;
  localparam int InDw    = 24;
  localparam int OutDw   = 32;

  localparam logic [4:0]  CTRL_RESET      = 5'b11111;
  localparam logic [4:0]  BANKS_RESET     = 5'd16;
  localparam logic [16:0] CHR_MASK_RESET  = 17'd8191;

  typedef struct packed {
    logic [4:0] ctrl;
    logic [4:0] chr_lo;
    logic [4:0] chr_hi;
    logic [4:0] prg;
  } bank_regs_t;

  typedef struct packed {
    logic        strobe;
    logic [1:0]  sel;
    logic [7:0]  data;
  } load_req_t;

  typedef struct packed {
    logic [1:0]       target;
    logic [MapAw-1:0] addr;
    logic             we;
    logic [7:0]       wdata;
  } map_res_t;

endpackage

/* hdl/smb_loader.sv */
module smb_loader (
  input  logic                  clk,
  input  logic                  rst_n,
  input  smb_pkg::load_req_t    req,
  output smb_pkg::bank_regs_t   regs,
  output logic [4:0]            ctrl_nxt
);
  import smb_pkg::*;

  logic [4:0]  shift_r, shift_nxt;
  logic [2:0]  count_r, count_nxt;
  bank_regs_t  regs_r, regs_nxt;
  logic [4:0]  shifted;
  logic [2:0]  count_inc;

  assign shifted   = {req.data[0], shift_r[4:1]};
  assign count_inc = count_r + 3'd1;

  always_comb begin
    shift_nxt = shift_r;
    count_nxt = count_r;
    regs_nxt  = regs_r;
    if (req.strobe) begin
      if (req.data[7]) begin
        // Load reset: restart the sequence and force program mode 3.
        shift_nxt     = '0;
        count_nxt     = '0;
        regs_nxt.ctrl = regs_r.ctrl | 5'b01100;
      end else if (count_inc >= 3'd5) begin
        shift_nxt = '0;
        count_nxt = '0;
        unique case (req.sel)
          SEL_CONTROL:  regs_nxt.ctrl   = shifted;
          SEL_CHR_LOW:  regs_nxt.chr_lo = shifted;
          SEL_CHR_HIGH: regs_nxt.chr_hi = shifted;
          SEL_PRG:      regs_nxt.prg    = shifted;
          default:      regs_nxt.prg    = shifted;
        endcase
      end else begin
        shift_nxt = shifted;
        count_nxt = count_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      shift_r       <= '0;
      count_r       <= '0;
      regs_r.ctrl   <= CTRL_RESET;
      regs_r.chr_lo <= '0;
      regs_r.chr_hi <= '0;
      regs_r.prg    <= '0;
    end else begin
      shift_r <= shift_nxt;
      count_r <= count_nxt;
      regs_r  <= regs_nxt;
    end
  end

  assign regs     = regs_r;
  assign ctrl_nxt = regs_nxt.ctrl;

endmodule

/* hdl/smb_xlate.sv */
module smb_xlate (
  input  logic                          valid,
  input  logic [1:0]                    kind,
  input  logic [15:0]                   address,
  input  logic [7:0]                    data,
  input  smb_pkg::bank_regs_t           regs,
  input  logic [4:0]                    prg_rom_banks,
  input  logic [smb_pkg::ChrAw-1:0]     chr_mask,
  input  logic                          prg_ram_present,
  output smb_pkg::load_req_t            load,
  output smb_pkg::map_res_t             res
);
  import smb_pkg::*;

  logic                  is_cpu, is_wr;
  logic                  in_ram, in_rom;
  logic [1:0]            mode;
  logic [3:0]            bank, last;
  logic [13:0]           off;
  logic [MapAw-1:0]      rom_addr;
  logic [ChrAw-1:0]      chr_raw;

  assign is_cpu = (kind == KIND_CPU_RD) || (kind == KIND_CPU_WR);
  assign is_wr  = (kind == KIND_CPU_WR) || (kind == KIND_PPU_WR);
  assign in_ram = (address[15:13] == 3'b011) && prg_ram_present;
  assign in_rom = address[15];

  assign mode = regs.ctrl[3:2];
  assign bank = regs.prg[3:0];
  assign off  = address[13:0];

  // Bank count clamps to 1..16 before the last bank is taken.
  always_comb begin
    if (prg_rom_banks == 5'd0) begin
      last = 4'd0;
    end else if (prg_rom_banks > 5'd16) begin
      last = 4'd15;
    end else begin
      last = 4'(prg_rom_banks - 5'd1);
    end
  end

  always_comb begin
    case (mode)
      2'd2:    rom_addr = address[14] ? {bank, off} : {4'd0, off};
      2'd3:    rom_addr = address[14] ? {last, off} : {bank, off};
      default: rom_addr = {bank[3:1], address[14:0]};
    endcase
  end

  assign chr_raw = regs.ctrl[4]
                 ? (address[12] ? {regs.chr_hi, address[11:0]}
                                : {regs.chr_lo, address[11:0]})
                 : {regs.chr_lo[4:1], address[12:0]};

  always_comb begin
    res         = '0;
    load.strobe = 1'b0;
    load.sel    = address[14:13];
    load.data   = data;
    if (is_cpu) begin
      if (in_ram) begin
        res.target = TGT_PRG_RAM;
        res.addr   = MapAw'(address[PrgRamAw-1:0]);
        res.we     = is_wr;
      end else if (in_rom) begin
        if (is_wr) begin
          load.strobe = valid;
        end else begin
          res.target = TGT_PRG_ROM;
          res.addr   = rom_addr;
        end
      end
    end else if (address[15:13] == 3'b000) begin
      res.target = TGT_CHR;
      res.addr   = MapAw'(chr_raw & chr_mask);
      res.we     = is_wr;
    end
    res.wdata = res.we ? data : 8'd0;
  end

endmodule

/* hdl/serial_loaded_bank_mapper.sv */
// Channel  Direction  tdata                                     tuser
// in       slave      address[15:0], data[23:16]                kind[1:0]
// out      master     mapped_address[17:0], write_enable[18],   target[1:0]
//                     write_data[26:19], mirror_mode[28:27]
// cfg      APB slave  prg_rom_banks 0x0, chr_address_mask 0x4, prg_ram_present 0x8
//
// One item per cycle unless the output stalls: an item is held in the input register,
// is translated and loads the output register, which drives out_tvalid.
// The serial load registers update as an item leaves the input register.
// Reset is synchronous and leaves control at 31 and the configuration at its defaults.
// A stalled output holds both stages; in_tready drops when both are full and
// out_tready is low.
module serial_loaded_bank_mapper (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [smb_pkg::InDw-1:0]      in_tdata,   // address[15:0], data[23:16]
  input  logic [1:0]                    in_tuser,   // kind[1:0]
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [smb_pkg::OutDw-1:0]     out_tdata,  // mapped_address, write_enable,
                                                    // write_data, mirror_mode, zero pad
  output logic [1:0]                    out_tuser,  // target[1:0]
  input  logic                          cfg_psel,
  input  logic                          cfg_penable,
  input  logic                          cfg_pwrite,
  input  logic [smb_pkg::CfgAw-1:0]     cfg_paddr,
  input  logic [31:0]                   cfg_pwdata,
  output logic [31:0]                   cfg_prdata,
  output logic                          cfg_pready
);
  import smb_pkg::*;

  logic              s1_valid_r, s1_valid_nxt;
  logic [1:0]        s1_kind_r;
  logic [15:0]       s1_addr_r;
  logic [7:0]        s1_data_r;
  logic              out_valid_r, out_valid_nxt;
  map_res_t          out_res_r;
  logic [1:0]        out_mirror_r;

  logic [4:0]        banks_r;
  logic [ChrAw-1:0]  chr_mask_r;
  logic              ram_present_r;

  logic              out_free, s1_move, in_fire, cfg_wr;
  bank_regs_t        regs;
  logic [4:0]        ctrl_nxt;
  load_req_t         load;
  map_res_t          res;

  assign out_free  = !out_valid_r || out_tready;
  assign s1_move   = s1_valid_r && out_free;
  assign in_tready = !s1_valid_r || out_free;
  assign in_fire   = in_tvalid && in_tready;

  smb_xlate u_xlate (
    .valid           (s1_move),
    .kind            (s1_kind_r),
    .address         (s1_addr_r),
    .data            (s1_data_r),
    .regs            (regs),
    .prg_rom_banks   (banks_r),
    .chr_mask        (chr_mask_r),
    .prg_ram_present (ram_present_r),
    .load            (load),
    .res             (res)
  );

  smb_loader u_loader (
    .clk      (clk),
    .rst_n    (rst_n),
    .req      (load),
    .regs     (regs),
    .ctrl_nxt (ctrl_nxt)
  );

  assign s1_valid_nxt  = in_fire || (s1_valid_r && !out_free);
  assign out_valid_nxt = s1_move || (out_valid_r && !out_tready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_kind_r <= in_tuser;
      s1_addr_r <= in_tdata[15:0];
      s1_data_r <= in_tdata[23:16];
    end
    if (s1_move) begin
      out_res_r    <= res;
      out_mirror_r <= ctrl_nxt[1:0];
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_res_r.target;
  assign out_tdata  = {3'd0, out_mirror_r, out_res_r.wdata, out_res_r.we, out_res_r.addr};

  // Configuration registers.
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      banks_r       <= BANKS_RESET;
      chr_mask_r    <= CHR_MASK_RESET;
      ram_present_r <= 1'b1;
    end else if (cfg_wr) begin
      unique case (cfg_paddr[3:2])
        REG_PRG_ROM_BANKS:    banks_r       <= cfg_pwdata[4:0];
        REG_CHR_ADDRESS_MASK: chr_mask_r    <= cfg_pwdata[ChrAw-1:0];
        REG_PRG_RAM_PRESENT:  ram_present_r <= cfg_pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_paddr[3:2])
      REG_PRG_ROM_BANKS:    cfg_prdata = {27'd0, banks_r};
      REG_CHR_ADDRESS_MASK: cfg_prdata = {15'd0, chr_mask_r};
      REG_PRG_RAM_PRESENT:  cfg_prdata = {31'd0, ram_present_r};
      default:              cfg_prdata = 32'd0;
    endcase
  end

endmodule
